// File: rtl/core/dpna_pkg.sv
// Shared constants and types for the defective pixel neighbour average block.
// Used by the controller, the datapath and the top level.
package dpna_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int PIXEL_BITS  = 16;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int WCNT_BITS   = COL_BITS + 1;
   localparam int FW_BITS     = 12;
   localparam int FH_BITS     = 16;
   localparam int MASK_BITS   = 9;
   localparam int CSR_BITS    = 16;
   localparam int EXT_BITS    = (WCNT_BITS > FW_BITS) ? WCNT_BITS : FW_BITS;
   localparam int ENTRY_BITS  = PIXEL_BITS + 1;
   localparam int SUM_BITS    = PIXEL_BITS + 3;
   localparam int STEP_BITS   = $clog2(SUM_BITS);
   localparam int WIN         = 3;

   localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
   localparam logic [1:0] REG_NEIGHBOUR_MASK = 2'd2;

   localparam logic CMD_DRAIN = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_EVAL,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic shift;
      logic eval;
      logic div_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic emit_due;
      logic need_div;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

// File: rtl/core/defective_pixel_neighbour_average.sv
// Channel | dir | payload
// req     | in  | tdata: pixel_value; tuser: cmd, is_defect
// rsp     | out | tdata: out_pixel; tuser: was_replaced; tlast: last_of_frame
// csr     | in  | index 0 frame_width, 1 frame_height, 2 neighbour_mask
// Each word is accepted, shifted and evaluated; the divider then runs when a defective
// pixel is replaced (one quotient bit per cycle), and a due result loads the output register.
// Reset is synchronous and clears the sequencer, position counters and window.
// Line stores are not cleared. A full output register stalls the sequencer only
// at hand-off; the next word is taken once the result is loaded.
// Depends on dpna_pkg, dpna_ctrl, dpna_datapath.
module defective_pixel_neighbour_average import dpna_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIXEL_BITS-1:0] req_tdata,   // [15:0] pixel_value
   input  logic [1:0]            req_tuser,   // [0] cmd, [1] is_defect
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PIXEL_BITS-1:0] rsp_tdata,   // [15:0] out_pixel
   output logic                  rsp_tuser,   // [0] was_replaced
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [CSR_BITS-1:0]   csr_wdata
);

   cmd_type    cmd;
   status_type status;

   dpna_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dpna_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

// File: rtl/core/dpna_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module dpna_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/dpna_ctrl.sv
// Sequencer for one word: shift the window, evaluate, divide, hand off the result.
// Depends on dpna_pkg.
module dpna_ctrl import dpna_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SHIFT;
         end
         ST_SHIFT: state_in = ST_EVAL;
         ST_EVAL: begin
            if (!status.emit_due) state_in = ST_IDLE;
            else if (status.need_div) state_in = ST_DIV;
            else state_in = ST_EMIT;
         end
         ST_DIV: begin
            if (status.div_last) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_SHIFT: cmd.shift    = 1'b1;
         ST_EVAL:  cmd.eval     = 1'b1;
         ST_DIV:   cmd.div_step = 1'b1;
         ST_EMIT:  cmd.emit     = status.out_free;
         default: ;
      endcase
   end

endmodule

// File: rtl/core/dpna_datapath.sv
// Line stores, 3x3 window, position counters, neighbour sum, divider, output register.
// Depends on dpna_pkg and dpna_ram.
module dpna_datapath import dpna_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [PIXEL_BITS-1:0] req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [CSR_BITS-1:0]   csr_wdata,
   output logic [PIXEL_BITS-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  cmd_type               cmd,
   output status_type            status
);

   logic [FW_BITS-1:0]    fw_ff;
   logic [FH_BITS-1:0]    fh_ff;
   logic [MASK_BITS-1:0]  mask_ff;
   logic [WCNT_BITS-1:0]  w_eff;
   logic [FH_BITS-1:0]    h_eff;
   logic [EXT_BITS-1:0]   fw_ext;

   logic [COL_BITS-1:0]   in_col_ff, in_col_in, col_now, col_ff;
   logic [FH_BITS-1:0]    in_row_ff, in_row_in;
   logic [COL_BITS-1:0]   out_col_ff, out_col_in;
   logic [FH_BITS-1:0]    out_row_ff, out_row_in;
   logic                  restart;

   logic [ENTRY_BITS-1:0] entry_ff;
   logic [ENTRY_BITS-1:0] top_rd, mid_rd;
   logic [ENTRY_BITS-1:0] win_ff [WIN*WIN];
   logic                  emit_ff;

   logic [SUM_BITS-1:0]   sum;
   logic [3:0]            cnt;
   logic [WIN-1:0]        row_ok, col_ok;
   logic                  centre_def;

   logic [SUM_BITS-1:0]   quo_ff;
   logic [2:0]            rem_ff;
   logic [3:0]            dvs_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic                  repl_ff;
   logic [PIXEL_BITS-1:0] pass_ff;
   logic [3:0]            trial;
   logic                  out_last;

   logic [PIXEL_BITS-1:0] rsp_data_ff;
   logic                  rsp_user_ff, rsp_last_ff, rsp_valid_ff;

   // Effective geometry: width clamps to 1..MAX_WIDTH, height zero acts as one.
   assign fw_ext = EXT_BITS'(fw_ff);
   always_comb begin
      if (fw_ff == '0) w_eff = WCNT_BITS'(1);
      else if (fw_ext > EXT_BITS'(MAX_WIDTH)) w_eff = WCNT_BITS'(MAX_WIDTH);
      else w_eff = WCNT_BITS'(fw_ff);
   end
   assign h_eff = (fh_ff == '0) ? FH_BITS'(1) : fh_ff;

   assign col_now = (WCNT_BITS'(in_col_ff) >= w_eff) ? '0 : in_col_ff;
   assign out_last = (out_row_ff == h_eff - FH_BITS'(1)) &&
                     (WCNT_BITS'(out_col_ff) + WCNT_BITS'(1) == w_eff);
   assign restart = cmd.emit && out_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff   <= FW_BITS'(640);
         fh_ff   <= FH_BITS'(480);
         mask_ff <= MASK_BITS'(495);
      end else if (csr_we) begin
         case (csr_index)
            REG_FRAME_WIDTH:    fw_ff   <= csr_wdata[FW_BITS-1:0];
            REG_FRAME_HEIGHT:   fh_ff   <= csr_wdata[FH_BITS-1:0];
            REG_NEIGHBOUR_MASK: mask_ff <= csr_wdata[MASK_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Input position advances when the window shifts.
   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      if (cmd.shift) begin
         if (WCNT_BITS'(col_ff) + WCNT_BITS'(1) >= w_eff) begin
            in_col_in = '0;
            if (in_row_ff != '1) in_row_in = in_row_ff + FH_BITS'(1);
         end else begin
            in_col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   always_comb begin
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (cmd.emit) begin
         if (WCNT_BITS'(out_col_ff) + WCNT_BITS'(1) == w_eff) begin
            out_col_in = '0;
            out_row_in = out_row_ff + FH_BITS'(1);
         end else begin
            out_col_in = out_col_ff + COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart ||
          (csr_we && (csr_index == REG_FRAME_WIDTH || csr_index == REG_FRAME_HEIGHT))) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // Capture the word; a drain word is a defective zero.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         col_ff   <= col_now;
         entry_ff <= (req_tuser[0] == CMD_DRAIN) ? {1'b1, {PIXEL_BITS{1'b0}}}
                                                 : {req_tuser[1], req_tdata};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff <= 1'b0;
      end else if (cmd.shift) begin
         emit_ff <= (in_row_ff >= FH_BITS'(2)) ||
                    ((in_row_ff == FH_BITS'(1)) && (col_ff != '0));
      end
   end

   dpna_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAX_WIDTH)) u_line_a (
      .clock (clock),
      .we    (cmd.shift),
      .waddr (col_ff),
      .wdata (entry_ff),
      .raddr (col_now),
      .rdata (mid_rd)
   );

   dpna_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAX_WIDTH)) u_line_b (
      .clock (clock),
      .we    (cmd.shift),
      .waddr (col_ff),
      .wdata (mid_rd),
      .raddr (col_now),
      .rdata (top_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN*WIN; i++) win_ff[i] <= '0;
      end else if (cmd.shift) begin
         for (int r = 0; r < WIN; r++) begin
            win_ff[r*WIN]   <= win_ff[r*WIN+1];
            win_ff[r*WIN+1] <= win_ff[r*WIN+2];
         end
         win_ff[2] <= top_rd;
         win_ff[5] <= mid_rd;
         win_ff[8] <= entry_ff;
      end
   end

   // Window edges that fall outside the frame.
   assign row_ok = {(out_row_ff + FH_BITS'(1) < h_eff), 1'b1, (out_row_ff != '0)};
   assign col_ok = {(WCNT_BITS'(out_col_ff) + WCNT_BITS'(1) < w_eff), 1'b1,
                    (out_col_ff != '0)};

   always_comb begin
      sum = '0;
      cnt = '0;
      for (int dy = 0; dy < WIN; dy++) begin
         for (int dx = 0; dx < WIN; dx++) begin
            if (row_ok[dy] && col_ok[dx] && mask_ff[dy*WIN+dx] &&
                !win_ff[dy*WIN+dx][PIXEL_BITS]) begin
               sum = sum + SUM_BITS'(win_ff[dy*WIN+dx][PIXEL_BITS-1:0]);
               cnt = cnt + 4'd1;
            end
         end
      end
   end

   assign centre_def = win_ff[4][PIXEL_BITS];

   // Restoring divider, one quotient bit per cycle.
   assign trial = {rem_ff, quo_ff[SUM_BITS-1]};
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         quo_ff  <= sum;
         dvs_ff  <= cnt;
         rem_ff  <= '0;
         step_ff <= '0;
         repl_ff <= centre_def && (cnt != '0);
         pass_ff <= win_ff[4][PIXEL_BITS-1:0];
      end else if (cmd.div_step) begin
         step_ff <= step_ff + STEP_BITS'(1);
         if (trial >= dvs_ff) begin
            rem_ff <= 3'(trial - dvs_ff);
            quo_ff <= {quo_ff[SUM_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= trial[2:0];
            quo_ff <= {quo_ff[SUM_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= repl_ff ? quo_ff[PIXEL_BITS-1:0] : pass_ff;
         rsp_user_ff <= repl_ff;
         rsp_last_ff <= out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tvalid = rsp_valid_ff;

   assign status.emit_due = emit_ff;
   assign status.need_div = centre_def && (cnt != '0);
   assign status.div_last = (step_ff == STEP_BITS'(SUM_BITS - 1));
   assign status.out_free = !rsp_valid_ff || rsp_tready;

endmodule
